/* sv/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
package bpa_pkg;

	localparam int TOP_ORDER_DEF  = 10;
	localparam int FRAME_BITS_DEF = 16;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOMEM    = 2'd1;
	localparam logic [1:0] ST_BADORDER = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  req_order;
		logic [15:0] block_pfn;
	} req_t;

	typedef struct packed {
		logic [15:0] result_pfn;
		logic [1:0]  status;
	} rsp_t;

endpackage

/* sv/buddy_page_allocator.sv */
// Buddy page allocator: per-order LIFO free lists, links held in a frame-indexed RAM.
//
// Request channel (req_valid / req_stall / req): one beat is an alloc or a
// free. Response channel (rsp_valid / rsp_stall / rsp): one beat per request.
// Requests are served one at a time; req_stall is high while a request is
// being worked on.
// An alloc searches upward one order at a time for a non-empty list, pops its
// head (link RAM read), then splits down to the requested order, pushing each upper half.
// A free checks at each merge level whether the buddy is on that order's list,
// walking it entry by entry (link RAM read per step); a found buddy is unlinked and the
// level rises, else the block is pushed onto that order's list; bad order goes straight to the result.
// The finished result sits in an output register; a new request is taken
// as soon as the result is loaded, even while the receiver stalls it.
// Reset empties all lists (heads and counts zero). The link RAM is not
// cleared: a link is always pushed before it is followed.
// While rsp_stall holds a waiting result, the next result is held back
// until the output register frees.
module buddy_page_allocator #(
	parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
	parameter int FRAME_BITS = bpa_pkg::FRAME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpa_pkg::rsp_t rsp
);
	import bpa_pkg::*;

	localparam int FB    = FRAME_BITS;
	localparam int CW    = FRAME_BITS + 1;
	localparam int ORD_W = (TOP_ORDER < 2) ? 1 : $clog2(TOP_ORDER + 1);
	localparam int NLIST = TOP_ORDER + 1;
	localparam logic [ORD_W-1:0] TOP = ORD_W'(TOP_ORDER);
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	typedef enum logic [3:0] {
		IDLE, A_SRCH, A_POP, A_SPLIT, F_CHK, F_WALK, F_ADV, F_UNL, FIN
	} state_t;

	state_t           state_q;
	logic [FB-1:0]    head_q  [NLIST];
	logic [CW-1:0]    count_q [NLIST];
	logic [ORD_W-1:0] ord_q, lvl_q;
	logic [FB-1:0]    frame_q, cur_q, prev_q;
	logic [CW-1:0]    k_q;
	logic [FB-1:0]    res_q;
	logic [1:0]       st_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [FB+15:0]   pfn_ext, res_ext;
	logic [FB-1:0]    pfn_in, buddy, rdata, split_frame;
	logic [ORD_W-1:0] lvl_dn;

	logic             push_en;
	logic [ORD_W-1:0] push_lvl;
	logic [FB-1:0]    push_frame;
	logic             we;
	logic [FB-1:0]    waddr, wdata, raddr;

	assign pfn_ext = {{FB{1'b0}}, req.block_pfn};
	assign pfn_in  = pfn_ext[FB-1:0];
	assign res_ext = {16'b0, res_q};

	assign buddy       = frame_q ^ (FB'(1) << lvl_q);
	assign lvl_dn      = lvl_q - ORD_W'(1);
	assign split_frame = frame_q + (FB'(1) << lvl_dn);

	// pushes: split halves during alloc, final block of a free
	always_comb begin
		push_en    = 1'b0;
		push_lvl   = lvl_q;
		push_frame = frame_q;
		unique case (state_q)
			A_SPLIT: begin
				if (lvl_q > ord_q) begin
					push_en    = 1'b1;
					push_lvl   = lvl_dn;
					push_frame = split_frame;
				end
			end
			F_CHK:  push_en = (lvl_q >= TOP);
			F_WALK: push_en = (k_q == count_q[lvl_q]);
			default: push_en = 1'b0;
		endcase
	end

	always_comb begin
		we    = push_en;
		waddr = push_frame;
		wdata = head_q[push_lvl];
		// unlink from the middle of a list: prev now skips cur
		if (state_q == F_UNL && k_q != '0) begin
			we    = 1'b1;
			waddr = prev_q;
			wdata = rdata;
		end
		raddr = (state_q == A_SRCH) ? head_q[lvl_q] : cur_q;
	end

	bpa_link_ram #(.AW(FB), .DW(FB)) u_link (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NLIST; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			// FIN reloads the output register itself
			if (rsp_valid_q && !rsp_stall && state_q != FIN)
				rsp_valid_q <= 1'b0;

			if (push_en) begin
				head_q[push_lvl] <= push_frame;
				if (count_q[push_lvl] != CNT_MAX)
					count_q[push_lvl] <= count_q[push_lvl] + CW'(1);
			end

			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						res_q   <= '0;
						st_q    <= ST_OK;
						frame_q <= pfn_in;
						ord_q   <= ORD_W'(req.req_order);
						lvl_q   <= ORD_W'(req.req_order);
						if (req.req_order > 4'(TOP_ORDER)) begin
							st_q    <= ST_BADORDER;
							state_q <= FIN;
						end else if (req.req_type == REQ_ALLOC) begin
							state_q <= A_SRCH;
						end else begin
							state_q <= F_CHK;
						end
					end
				end
				A_SRCH: begin
					if (count_q[lvl_q] != '0) begin
						state_q <= A_POP;
					end else if (lvl_q == TOP) begin
						st_q    <= ST_NOMEM;
						state_q <= FIN;
					end else begin
						lvl_q <= lvl_q + ORD_W'(1);
					end
				end
				A_POP: begin
					frame_q         <= head_q[lvl_q];
					head_q[lvl_q]   <= rdata;
					count_q[lvl_q]  <= count_q[lvl_q] - CW'(1);
					state_q         <= A_SPLIT;
				end
				A_SPLIT: begin
					if (lvl_q > ord_q) begin
						lvl_q <= lvl_dn;
					end else begin
						res_q   <= frame_q;
						state_q <= FIN;
					end
				end
				F_CHK: begin
					if (lvl_q >= TOP) begin
						state_q <= FIN;
					end else begin
						cur_q   <= head_q[lvl_q];
						k_q     <= '0;
						state_q <= F_WALK;
					end
				end
				F_WALK: begin
					if (k_q == count_q[lvl_q])
						state_q <= FIN;
					else if (cur_q == buddy)
						state_q <= F_UNL;
					else
						state_q <= F_ADV;
				end
				F_ADV: begin
					prev_q  <= cur_q;
					cur_q   <= rdata;
					k_q     <= k_q + CW'(1);
					state_q <= F_WALK;
				end
				F_UNL: begin
					if (k_q == '0)
						head_q[lvl_q] <= rdata;
					count_q[lvl_q] <= count_q[lvl_q] - CW'(1);
					if (buddy < frame_q)
						frame_q <= buddy;
					lvl_q   <= lvl_q + ORD_W'(1);
					state_q <= F_CHK;
				end
				FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.result_pfn <= res_ext[15:0];
						rsp_q.status     <= st_q;
						rsp_valid_q      <= 1'b1;
						state_q          <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sv/bpa_link_ram.sv */
// Next-link memory: one write port, one read port, registered read data.
module bpa_link_ram #(
	parameter int AW = 16,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
